@@ hw/rtl/ecpu_pkg.sv @@
// ecpu_pkg: types, constants and helper functions of the camera pose update block
// no dependencies; imported by the request and response interfaces and every module of the block
`default_nettype none

package ecpu_pkg;

   localparam int TrigIterations = 14;
   localparam int TrigSteps      = (TrigIterations < 20) ? TrigIterations : 20;

   localparam int AngW  = 36;   // Q2.30 angle with headroom for the wrap
   localparam int TrigW = 34;   // Q2.30 sine and cosine
   localparam int MulW  = 34;   // operand width of the serial multiplier
   localparam int ProdW = 2 * MulW;
   localparam int DotW  = 50;   // sum of three basis by velocity or position products
   localparam int SumW  = 36;

   localparam int BasisSteps = 14;

   localparam logic signed [AngW-1:0]  AngPi      = 36'sd3373259426;
   localparam logic signed [AngW-1:0]  AngHalfPi  = 36'sd1686629713;
   localparam logic signed [AngW-1:0]  AngTwoPi   = 36'sd6746518852;
   localparam logic signed [TrigW-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [15:0]      PitchLimit = 16'sd6144;
   localparam logic signed [SumW-1:0]  OneQ14     = 36'sd16384;

   typedef enum logic {
      OP_TICK     = 1'b0,
      OP_SET_POSE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CORDIC_IDLE,
      CORDIC_FOLD,
      CORDIC_ITER,
      CORDIC_DONE
   } cordic_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG_START,
      ST_TRIG_WAIT,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_BASIS,
      PH_VEL,
      PH_TRANS
   } phase_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [31:0] vel_right;
      logic signed [31:0] vel_up;
      logic signed [31:0] vel_forward;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [31:0] trans_right;
      logic signed [31:0] trans_up;
      logic signed [31:0] trans_forward;
   } rsp_type;

   function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [AngW-1:0] r;
      unique case (idx)
         5'd0:  r = 36'sh03243F6A8;
         5'd1:  r = 36'sh01DAC6705;
         5'd2:  r = 36'sh00FADBAFC;
         5'd3:  r = 36'sh007F56EA6;
         5'd4:  r = 36'sh003FEAB76;
         5'd5:  r = 36'sh001FFD55B;
         5'd6:  r = 36'sh000FFFAAA;
         5'd7:  r = 36'sh0007FFF55;
         5'd8:  r = 36'sh0003FFFEA;
         5'd9:  r = 36'sh0001FFFFD;
         5'd10: r = 36'sh0000FFFFF;
         5'd11: r = 36'sh00007FFFF;
         5'd12: r = 36'sh00003FFFF;
         5'd13: r = 36'sh00001FFFF;
         5'd14: r = 36'sh00000FFFF;
         5'd15: r = 36'sh000007FFF;
         5'd16: r = 36'sh000003FFF;
         5'd17: r = 36'sh000001FFF;
         5'd18: r = 36'sh000000FFF;
         5'd19: r = 36'sh0000007FF;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q2.30 sum to Q1.14, rounded and clamped to plus or minus one
   function automatic logic signed [15:0] to_q14(input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] t;
      t = (v + 36'sd32768) >>> 16;
      if (t > OneQ14) begin
         t = OneQ14;
      end else if (t < -OneQ14) begin
         t = -OneQ14;
      end
      return t[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > 37'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -37'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ecpu_ifs.sv @@
// ecpu request, response and register write channels
// depends on ecpu_pkg for the payload types
`default_nettype none

interface ecpu_req_if;
   import ecpu_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ecpu_rsp_if;
   import ecpu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ecpu_csr_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ecpu_cordic.sv @@
// ecpu_cordic: iterative rotation-mode cordic, one step per cycle, gives sine and cosine
// depends on ecpu_pkg for widths, the arctangent table and the state type
`default_nettype none

module ecpu_cordic (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [15:0]                angle,
   output logic                                   done,
   output logic signed [ecpu_pkg::TrigW-1:0]      cos_val,
   output logic signed [ecpu_pkg::TrigW-1:0]      sin_val
);
   import ecpu_pkg::*;

   cordic_state_type       state_ff, state_in;
   logic signed [AngW-1:0] ang_ff, ang_in;
   logic signed [TrigW-1:0] x_ff, x_in, y_ff, y_in;
   logic                   neg_ff, neg_in;
   logic [4:0]             iter_ff, iter_in;

   logic signed [AngW-1:0]  ang_ext, ang_wrap;
   logic signed [TrigW-1:0] x_sh, y_sh;
   logic                    last_iter;

   assign ang_ext   = {{2{angle[15]}}, angle, 18'd0};
   assign x_sh      = x_ff >>> iter_ff;
   assign y_sh      = y_ff >>> iter_ff;
   assign last_iter = (iter_ff == 5'(TrigSteps - 1));

   always_comb begin
      if (ang_ext > AngPi) begin
         ang_wrap = ang_ext - AngTwoPi;
      end else if (ang_ext < -AngPi) begin
         ang_wrap = ang_ext + AngTwoPi;
      end else begin
         ang_wrap = ang_ext;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CORDIC_IDLE: if (start) state_in = CORDIC_FOLD;
         CORDIC_FOLD: state_in = CORDIC_ITER;
         CORDIC_ITER: if (last_iter) state_in = CORDIC_DONE;
         CORDIC_DONE: state_in = CORDIC_IDLE;
         default:     state_in = CORDIC_IDLE;
      endcase
   end

   always_comb begin
      ang_in  = ang_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      unique case (state_ff)
         CORDIC_IDLE: begin
            ang_in  = ang_wrap;
            x_in    = CordicGain;
            y_in    = '0;
            neg_in  = 1'b0;
            iter_in = '0;
         end
         CORDIC_FOLD: begin
            // bring the angle into the right half plane, flip the result later
            if (ang_ff > AngHalfPi) begin
               ang_in = ang_ff - AngPi;
               neg_in = 1'b1;
            end else if (ang_ff < -AngHalfPi) begin
               ang_in = ang_ff + AngPi;
               neg_in = 1'b1;
            end
         end
         CORDIC_ITER: begin
            if (!ang_ff[AngW-1]) begin
               x_in   = x_ff - y_sh;
               y_in   = y_ff + x_sh;
               ang_in = ang_ff - atan_q30(iter_ff);
            end else begin
               x_in   = x_ff + y_sh;
               y_in   = y_ff - x_sh;
               ang_in = ang_ff + atan_q30(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORDIC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ang_ff  <= ang_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      neg_ff  <= neg_in;
      iter_ff <= iter_in;
   end

   assign done    = (state_ff == CORDIC_DONE);
   assign cos_val = neg_ff ? -x_ff : x_ff;
   assign sin_val = neg_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ecpu_serial_mul.sv @@
// ecpu_serial_mul: signed bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on ecpu_pkg for the operand and product widths
`default_nettype none

module ecpu_serial_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [ecpu_pkg::MulW-1:0]  mcand,
   input  wire logic signed [ecpu_pkg::MulW-1:0]  mplier,
   output logic                                   done,
   output logic signed [ecpu_pkg::ProdW-1:0]      product
);
   import ecpu_pkg::*;

   logic signed [MulW+1:0] acc_ff;
   logic [MulW-1:0]        lo_ff;
   logic signed [MulW-1:0] mcand_ff;
   logic [5:0]             cnt_ff;
   logic                   busy_ff, done_ff;

   logic signed [MulW+1:0] addend, sum;
   logic                   last_bit;
   logic [2*MulW+1:0]      full;

   assign last_bit = (cnt_ff == 6'(MulW - 1));

   // the top multiplier bit carries negative weight
   always_comb begin
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (last_bit) begin
         addend = -(MulW+2)'(mcand_ff);
      end else begin
         addend = (MulW+2)'(mcand_ff);
      end
   end

   assign sum = acc_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last_bit;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_bit) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         acc_ff   <= '0;
         lo_ff    <= mplier;
         mcand_ff <= mcand;
         cnt_ff   <= '0;
      end else if (busy_ff) begin
         acc_ff <= sum >>> 1;
         lo_ff  <= {sum[0], lo_ff[MulW-1:1]};
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   assign full    = {acc_ff, lo_ff};
   assign product = full[ProdW-1:0];
   assign done    = done_ff;

endmodule

`default_nettype wire

@@ hw/rtl/euler_camera_pose_update.sv @@
// euler_camera_pose_update: fly camera pose update and yxz euler view matrix
// depends on ecpu_pkg, ecpu_ifs, ecpu_cordic and ecpu_serial_mul
//
// One request at a time. Sine and cosine of yaw, pitch and roll come one after the
// other from a single cordic, each angle passing start, fold, 14 steps and done. All
// products then go through one bit-serial multiplier (start, 34 bit steps, done
// each): 14 for the basis, 9 for the position move of a tick and 9 for the
// translation column. The response is held until taken; the next request is
// accepted after that. The roll register is always ready for writes.
`default_nettype none

module euler_camera_pose_update (
   input wire logic   clock,
   input wire logic   reset,
   ecpu_req_if.sink   req_ch,
   ecpu_rsp_if.source rsp_ch,
   ecpu_csr_if.sink   csr_ch
);
   import ecpu_pkg::*;

   state_type   state_ff, state_in;
   phase_type   ph_ff;
   op_type      op_ff;
   logic [1:0]  trig_idx_ff, k_ff, n_ff;
   logic [3:0]  step_ff;

   logic signed [15:0]       roll_ff, pitch_ff, yaw_ff;
   logic signed [31:0]       vel_ff [3];
   logic signed [31:0]       pos_ff [3];
   logic signed [31:0]       trans_ff [3];
   logic signed [15:0]       basis_ff [9];
   logic signed [TrigW-1:0]  cs_ff [3];
   logic signed [TrigW-1:0]  sn_ff [3];
   logic signed [TrigW-1:0]  m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [DotW-1:0]   dacc_ff;

   logic                    req_ready, rsp_valid, cordic_start, mul_start;
   logic                    cordic_done, mul_done, last_mul;
   logic signed [15:0]      cordic_angle, pitch_clamped;
   logic signed [TrigW-1:0] cordic_cos, cordic_sin;
   logic signed [MulW-1:0]  op_a, op_b;
   logic signed [ProdW-1:0] product, prod_rnd;
   logic signed [TrigW-1:0] r30;
   logic signed [DotW-1:0]  dsum, dsum_rnd;
   logic signed [SumW-1:0]  dshift;
   logic [3:0]              bidx;

   ecpu_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_val (cordic_cos),
      .sin_val (cordic_sin)
   );

   ecpu_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (op_a),
      .mplier  (op_b),
      .done    (mul_done),
      .product (product)
   );

   assign last_mul = (ph_ff == PH_TRANS) && (k_ff == 2'd2) && (n_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_ch.valid) state_in = ST_TRIG_START;
         ST_TRIG_START: state_in = ST_TRIG_WAIT;
         ST_TRIG_WAIT: begin
            if (cordic_done) begin
               state_in = (trig_idx_ff == 2'd2) ? ST_MUL_START : ST_TRIG_START;
            end
         end
         ST_MUL_START:  state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = last_mul ? ST_RESP : ST_MUL_START;
            end
         end
         ST_RESP:       if (rsp_ch.ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cordic_start = 1'b0;
      mul_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE:       req_ready = 1'b1;
         ST_TRIG_START: cordic_start = 1'b1;
         ST_MUL_START:  mul_start = 1'b1;
         ST_RESP:       rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      if (req_ch.data.op == OP_TICK && req_ch.data.pitch_angle > PitchLimit) begin
         pitch_clamped = PitchLimit;
      end else if (req_ch.data.op == OP_TICK && req_ch.data.pitch_angle < -PitchLimit) begin
         pitch_clamped = -PitchLimit;
      end else begin
         pitch_clamped = req_ch.data.pitch_angle;
      end
   end

   always_comb begin
      unique case (trig_idx_ff)
         2'd0:    cordic_angle = yaw_ff;
         2'd1:    cordic_angle = pitch_ff;
         default: cordic_angle = roll_ff;
      endcase
   end

   // basis products follow a fixed schedule, dot products walk rows and columns
   assign bidx = (ph_ff == PH_VEL) ? 4'(n_ff) * 4'd3 + 4'(k_ff)
                                   : 4'(k_ff) * 4'd3 + 4'(n_ff);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (ph_ff)
         PH_BASIS: begin
            unique case (step_ff)
               4'd0:    begin op_a = cs_ff[0]; op_b = cs_ff[2]; end
               4'd1:    begin op_a = sn_ff[0]; op_b = sn_ff[1]; end
               4'd2:    begin op_a = m1_ff;    op_b = sn_ff[2]; end
               4'd3:    begin op_a = cs_ff[1]; op_b = sn_ff[2]; end
               4'd4:    begin op_a = cs_ff[0]; op_b = sn_ff[1]; end
               4'd5:    begin op_a = m1_ff;    op_b = sn_ff[2]; end
               4'd6:    begin op_a = cs_ff[2]; op_b = sn_ff[0]; end
               4'd7:    begin op_a = m3_ff;    op_b = sn_ff[1]; end
               4'd8:    begin op_a = cs_ff[0]; op_b = sn_ff[2]; end
               4'd9:    begin op_a = cs_ff[1]; op_b = cs_ff[2]; end
               4'd10:   begin op_a = m0_ff;    op_b = sn_ff[1]; end
               4'd11:   begin op_a = sn_ff[0]; op_b = sn_ff[2]; end
               4'd12:   begin op_a = cs_ff[1]; op_b = sn_ff[0]; end
               default: begin op_a = cs_ff[0]; op_b = cs_ff[1]; end
            endcase
         end
         PH_VEL: begin
            op_a = MulW'(basis_ff[bidx]);
            op_b = MulW'(vel_ff[n_ff]);
         end
         default: begin
            op_a = MulW'(basis_ff[bidx]);
            op_b = MulW'(pos_ff[n_ff]);
         end
      endcase
   end

   assign prod_rnd = product + (ProdW'(1) <<< 29);
   assign r30      = prod_rnd[63:30];
   assign dsum     = ((n_ff == 2'd0) ? DotW'(0) : dacc_ff) + product[DotW-1:0];
   assign dsum_rnd = (dsum + DotW'(8192)) >>> 14;
   assign dshift   = dsum_rnd[SumW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         roll_ff     <= '0;
         pos_ff[0]   <= '0;
         pos_ff[1]   <= '0;
         pos_ff[2]   <= '0;
         trig_idx_ff <= '0;
         ph_ff       <= PH_BASIS;
         step_ff     <= '0;
         k_ff        <= '0;
         n_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            roll_ff <= csr_ch.data;
         end
         if (state_ff == ST_IDLE && req_ch.valid) begin
            trig_idx_ff <= '0;
            ph_ff       <= PH_BASIS;
            step_ff     <= '0;
            k_ff        <= '0;
            n_ff        <= '0;
            if (req_ch.data.op == OP_SET_POSE) begin
               pos_ff[0] <= req_ch.data.pos_x;
               pos_ff[1] <= req_ch.data.pos_y;
               pos_ff[2] <= req_ch.data.pos_z;
            end
         end
         if (state_ff == ST_TRIG_WAIT && cordic_done) begin
            trig_idx_ff <= trig_idx_ff + 2'd1;
         end
         if (state_ff == ST_MUL_WAIT && mul_done) begin
            unique case (ph_ff)
               PH_BASIS: begin
                  if (step_ff == 4'(BasisSteps - 1)) begin
                     ph_ff <= (op_ff == OP_TICK) ? PH_VEL : PH_TRANS;
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end
               PH_VEL: begin
                  if (n_ff == 2'd2) begin
                     n_ff      <= '0;
                     pos_ff[k_ff] <= sat32(37'(pos_ff[k_ff]) + 37'(dshift));
                     if (k_ff == 2'd2) begin
                        k_ff  <= '0;
                        ph_ff <= PH_TRANS;
                     end else begin
                        k_ff <= k_ff + 2'd1;
                     end
                  end else begin
                     n_ff <= n_ff + 2'd1;
                  end
               end
               default: begin
                  if (n_ff == 2'd2) begin
                     n_ff <= '0;
                     if (k_ff != 2'd2) begin
                        k_ff <= k_ff + 2'd1;
                     end
                  end else begin
                     n_ff <= n_ff + 2'd1;
                  end
               end
            endcase
         end
      end

      if (state_ff == ST_IDLE && req_ch.valid) begin
         op_ff     <= req_ch.data.op;
         pitch_ff  <= pitch_clamped;
         yaw_ff    <= req_ch.data.yaw_angle;
         vel_ff[0] <= req_ch.data.vel_right;
         vel_ff[1] <= req_ch.data.vel_up;
         vel_ff[2] <= req_ch.data.vel_forward;
      end
      if (state_ff == ST_TRIG_WAIT && cordic_done) begin
         cs_ff[trig_idx_ff] <= cordic_cos;
         sn_ff[trig_idx_ff] <= cordic_sin;
      end
      if (state_ff == ST_MUL_WAIT && mul_done) begin
         dacc_ff <= dsum;
         if (ph_ff == PH_TRANS && n_ff == 2'd2) begin
            trans_ff[k_ff] <= sat32(-37'(dshift));
         end
         if (ph_ff == PH_BASIS) begin
            unique case (step_ff)
               4'd0: begin
                  m0_ff       <= r30;
                  basis_ff[7] <= to_q14(-SumW'(sn_ff[1]));
               end
               4'd1:    m1_ff <= r30;
               4'd2:    basis_ff[0] <= to_q14(SumW'(m0_ff) + SumW'(r30));
               4'd3:    basis_ff[1] <= to_q14(SumW'(r30));
               4'd4:    m1_ff <= r30;
               4'd5:    m2_ff <= r30;
               4'd6: begin
                  m3_ff       <= r30;
                  basis_ff[2] <= to_q14(SumW'(m2_ff) - SumW'(r30));
               end
               4'd7:    m2_ff <= r30;
               4'd8:    basis_ff[3] <= to_q14(SumW'(m2_ff) - SumW'(r30));
               4'd9:    basis_ff[4] <= to_q14(SumW'(r30));
               4'd10:   m2_ff <= r30;
               4'd11:   basis_ff[5] <= to_q14(SumW'(m2_ff) + SumW'(r30));
               4'd12:   basis_ff[6] <= to_q14(SumW'(r30));
               default: basis_ff[8] <= to_q14(SumW'(r30));
            endcase
         end
      end
   end

   assign rsp_ch.data.right_x       = basis_ff[0];
   assign rsp_ch.data.right_y       = basis_ff[1];
   assign rsp_ch.data.right_z       = basis_ff[2];
   assign rsp_ch.data.up_x          = basis_ff[3];
   assign rsp_ch.data.up_y          = basis_ff[4];
   assign rsp_ch.data.up_z          = basis_ff[5];
   assign rsp_ch.data.fwd_x         = basis_ff[6];
   assign rsp_ch.data.fwd_y         = basis_ff[7];
   assign rsp_ch.data.fwd_z         = basis_ff[8];
   assign rsp_ch.data.trans_right   = trans_ff[0];
   assign rsp_ch.data.trans_up      = trans_ff[1];
   assign rsp_ch.data.trans_forward = trans_ff[2];

   a_req_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == ST_TRIG_START)
      else $error("accepted request did not start the sine and cosine pass");

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL_WAIT)
      else $error("multiplier finished outside the product wait state");

   a_cordic_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_TRIG_WAIT)
      else $error("cordic finished outside the trig wait state");

   a_basis_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> basis_ff[4] <= 16'sd16384 && basis_ff[4] >= -16'sd16384
                 && basis_ff[7] <= 16'sd16384 && basis_ff[7] >= -16'sd16384)
      else $error("basis component beyond unit range");

   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ch.ready |=> state_ff == ST_IDLE)
      else $error("response taken but block did not return to idle");

endmodule

`default_nettype wire

@@ sim/euler_camera_pose_update_test.sv @@
// testbench for euler_camera_pose_update: directed and random pose updates with a local predictor
// depends on ecpu_pkg and ecpu_ifs from the rtl, and on the block itself
`timescale 1ns / 100ps

module euler_camera_pose_update_test;
   import ecpu_pkg::*;

   localparam longint AnglePi     = 64'sd3373259426;
   localparam longint AngleHalfPi = 64'sd1686629713;
   localparam longint AngleTwoPi  = 64'sd6746518852;
   localparam longint TrigGain    = 64'sd652032874;
   localparam int     PitchClamp  = 6144;

   logic clock;
   logic reset;

   ecpu_req_if req_ch ();
   ecpu_rsp_if rsp_ch ();
   ecpu_csr_if csr_ch ();

   euler_camera_pose_update i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic signed [31:0] cam_pos [3];
   logic signed [15:0] roll_reg;
   rsp_type            view_queue [$];

   int  error_count;
   int  request_count;
   int  view_count;
   int  tick_count;
   int  pose_count;
   int  stall_left;
   bit  idle_en;

   longint arctan_q30 [20] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
   };

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint basis_q14(input longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) begin
         r = 16384;
      end else if (r < -16384) begin
         r = -16384;
      end
      return r;
   endfunction

   // rotation-mode cordic after folding the angle into plus or minus half pi
   task automatic trig(input logic signed [15:0] ang, output longint c, output longint s);
      longint a;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      a = longint'(ang) * 262144;
      x = TrigGain;
      y = 0;
      flip = 1'b0;
      while (a > AnglePi) a -= AngleTwoPi;
      while (a < -AnglePi) a += AngleTwoPi;
      if (a > AngleHalfPi) begin
         a -= AnglePi;
         flip = 1'b1;
      end else if (a < -AngleHalfPi) begin
         a += AnglePi;
         flip = 1'b1;
      end
      for (int i = 0; i < TrigSteps; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            a -= arctan_q30[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            a += arctan_q30[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_view(input req_type r);
      longint        b [9];
      longint        c1, s1, c2, s2, c3, s3;
      longint        acc;
      logic signed [15:0] pitch;
      rsp_type       v;
      pitch = r.pitch_angle;
      if (r.op == OP_TICK) begin
         if (pitch > PitchClamp) pitch = PitchClamp;
         if (pitch < -PitchClamp) pitch = -PitchClamp;
      end
      trig(r.yaw_angle, c1, s1);
      trig(pitch, c2, s2);
      trig(roll_reg, c3, s3);
      b[0] = basis_q14(qmul(c1, c3) + qmul(qmul(s1, s2), s3));
      b[1] = basis_q14(qmul(c2, s3));
      b[2] = basis_q14(qmul(qmul(c1, s2), s3) - qmul(c3, s1));
      b[3] = basis_q14(qmul(qmul(c3, s1), s2) - qmul(c1, s3));
      b[4] = basis_q14(qmul(c2, c3));
      b[5] = basis_q14(qmul(qmul(c1, c3), s2) + qmul(s1, s3));
      b[6] = basis_q14(qmul(c2, s1));
      b[7] = basis_q14(-s2);
      b[8] = basis_q14(qmul(c1, c2));
      if (r.op == OP_TICK) begin
         for (int k = 0; k < 3; k++) begin
            acc = b[k] * longint'(r.vel_right) + b[3+k] * longint'(r.vel_up)
                + b[6+k] * longint'(r.vel_forward);
            cam_pos[k] = clamp32(longint'(cam_pos[k]) + ((acc + 8192) >>> 14));
         end
         tick_count++;
      end else begin
         cam_pos[0] = r.pos_x;
         cam_pos[1] = r.pos_y;
         cam_pos[2] = r.pos_z;
         pose_count++;
      end
      v.right_x = b[0]; v.right_y = b[1]; v.right_z = b[2];
      v.up_x    = b[3]; v.up_y    = b[4]; v.up_z    = b[5];
      v.fwd_x   = b[6]; v.fwd_y   = b[7]; v.fwd_z   = b[8];
      for (int k = 0; k < 3; k++) begin
         acc = b[3*k] * longint'(cam_pos[0]) + b[3*k+1] * longint'(cam_pos[1])
             + b[3*k+2] * longint'(cam_pos[2]);
         acc = clamp32(-((acc + 8192) >>> 14));
         if (k == 0) v.trans_right = acc;
         else if (k == 1) v.trans_up = acc;
         else v.trans_forward = acc;
      end
      view_queue.push_back(v);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: random stall bursts while idle_en is set, each taken response checked against the predictor
   always @(posedge clock) begin
      rsp_type w;
      rsp_type g;
      if (reset) begin
         stall_left <= 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
         end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 9);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            g = rsp_ch.data;
            view_count++;
            if (view_queue.size() == 0) begin
               $display("%0t: unexpected view matrix response", $time);
               error_count++;
            end else begin
               w = view_queue.pop_front();
               check_field("right_x", w.right_x, g.right_x);
               check_field("right_y", w.right_y, g.right_y);
               check_field("right_z", w.right_z, g.right_z);
               check_field("up_x", w.up_x, g.up_x);
               check_field("up_y", w.up_y, g.up_y);
               check_field("up_z", w.up_z, g.up_z);
               check_field("fwd_x", w.fwd_x, g.fwd_x);
               check_field("fwd_y", w.fwd_y, g.fwd_y);
               check_field("fwd_z", w.fwd_z, g.fwd_z);
               check_field("trans_right", w.trans_right, g.trans_right);
               check_field("trans_up", w.trans_up, g.trans_up);
               check_field("trans_forward", w.trans_forward, g.trans_forward);
            end
         end
      end
   end

   task automatic send_request(input req_type r);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_view(r);
      request_count++;
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (view_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_roll(input logic signed [15:0] val);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      roll_reg = val;
   endtask

   function automatic req_type make_request(input op_type op, input int pitch, input int yaw,
                                            input int vr, input int vu, input int vf,
                                            input int px, input int py, input int pz);
      req_type r;
      r.op = op;
      r.pitch_angle = 16'(pitch);
      r.yaw_angle = 16'(yaw);
      r.vel_right = vr;
      r.vel_up = vu;
      r.vel_forward = vf;
      r.pos_x = px;
      r.pos_y = py;
      r.pos_z = pz;
      return r;
   endfunction

   function automatic int pick_word(input bit wide);
      if (wide || $urandom_range(0, 7) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
   endfunction

   function automatic req_type random_request;
      req_type r;
      r.op = ($urandom_range(0, 3) == 0) ? OP_SET_POSE : OP_TICK;
      r.pitch_angle = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 14000) - 7000);
      r.yaw_angle = 16'($urandom);
      r.vel_right = pick_word(1'b0);
      r.vel_up = pick_word(1'b0);
      r.vel_forward = pick_word(1'b0);
      r.pos_x = pick_word(1'($urandom_range(0, 1)));
      r.pos_y = pick_word(1'($urandom_range(0, 1)));
      r.pos_z = pick_word(1'($urandom_range(0, 1)));
      return r;
   endfunction

   // field extremes, pitch clamp edges, angle wrap and both saturations
   task automatic test_directed;
      send_request(make_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_TICK, 6144, 0, 65536, 0, 0, 0, 0, 0));
      send_request(make_request(OP_TICK, 6145, 0, 0, 65536, 0, 0, 0, 0));
      send_request(make_request(OP_TICK, -6145, 32767, 0, 0, 65536, 0, 0, 0));
      send_request(make_request(OP_TICK, 32767, -32768, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_TICK, -32768, 12868, 0, 0, 0, -1, -1, -1));
      send_request(make_request(OP_SET_POSE, 32767, -12868, -1, -1, -1,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      send_request(make_request(OP_TICK, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                0, 0, 0));
      send_request(make_request(OP_TICK, 3000, 6434, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                32'h7FFFFFFF, 0, 0, 0));
      send_request(make_request(OP_SET_POSE, -32768, 32767, 0, 0, 0,
                                32'h80000000, 32'h80000000, 32'h80000000));
      send_request(make_request(OP_TICK, -3000, -6434, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h7FFFFFFF, 0, 0));
      send_request(make_request(OP_SET_POSE, 6433, 25736, 0, 0, 0,
                                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
      send_request(make_request(OP_SET_POSE, -6433, -25736, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_TICK, 6434, 6433, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0));
   endtask

   task automatic test_roll_settings;
      logic signed [15:0] rolls [4] = '{16'sh7FFF, 16'sh8000, 16'sd6434, -16'sd12868};
      foreach (rolls[i]) begin
         write_roll(rolls[i]);
         repeat (6) send_request(random_request());
      end
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 120 == 119) begin
            write_roll(16'($urandom));
         end
         send_request(random_request());
      end
   endtask

   initial begin
      reset = 1'b1;
      idle_en = 1'b1;
      error_count = 0;
      request_count = 0;
      view_count = 0;
      tick_count = 0;
      pose_count = 0;
      cam_pos = '{0, 0, 0};
      roll_reg = 0;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_roll_settings();
      write_roll(16'sd0);
      test_random(550);
      drain();
      idle_en = 1'b0;
      test_random(60);
      drain();
      while (view_queue.size() != 0) @(posedge clock);
      repeat (1300) @(posedge clock);
      $display("%0d requests (%0d ticks, %0d set pose), %0d view matrices checked",
               request_count, tick_count, pose_count, view_count);
      $display("covered pitch clamp, angle wrap, roll extremes and position saturation");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout with %0d responses outstanding", view_queue.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ecpu_pkg.sv
hw/rtl/ecpu_ifs.sv
hw/rtl/ecpu_cordic.sv
hw/rtl/ecpu_serial_mul.sv
hw/rtl/euler_camera_pose_update.sv
sim/euler_camera_pose_update_test.sv
